### sv/lrucs_pkg.sv
// ----------------------------------------------------------------------------
// lrucs_pkg: shared definitions for the LRU cache store
// Default sizes, capacity register format and controller state encoding.
// ----------------------------------------------------------------------------
package lrucs_pkg;

  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_KEY_BITS  = 48;
  localparam int DEF_DATA_BITS = 64;

  localparam int              CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_FIND,   // lookup: scan keys for the most recent match
    ST_TOUCH,  // lookup hit: rewrite ranks, hit entry to front
    ST_PUT,    // insert: rerank and compact in place
    ST_PLACE,  // insert into a non-full store: append the new entry
    ST_DONE    // result waiting for the output register
  } state_t;

endpackage

### sv/lru_cache_store.sv
// ----------------------------------------------------------------------------
// lru_cache_store: fully associative recency-ordered key/payload store
// Entries live in one single-port-read, single-port-write RAM holding key,
// payload and recency rank; every operation is a sweep over the RAM.
// ----------------------------------------------------------------------------
// Lookup miss: one key sweep over the n entries stored when the item is accepted;
//   lookup hit: key sweep, then rank rewrite sweep; insert: rerank sweep over all
//   slots when full, else over the n entries and then an append; one entry per cycle.
// One item at a time: the next is accepted in the cycle after the result loads.
// Reset (rst, synchronous): store empty, capacity 16, no result pending.
// RAM contents need no clearing, only slots below the count are read.
module lru_cache_store #(
  parameter int ENTRIES   = lrucs_pkg::DEF_ENTRIES,
  parameter int KEY_BITS  = lrucs_pkg::DEF_KEY_BITS,
  parameter int DATA_BITS = lrucs_pkg::DEF_DATA_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: capacity register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lrucs_pkg::CAP_W-1:0] cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [KEY_BITS-1:0]         key,
  input  logic [DATA_BITS-1:0]        payload,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [DATA_BITS-1:0]        payload_out,
  output logic                        evicted
);
  import lrucs_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int EXT_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
    logic [IDX_W-1:0]     rank;
  } entry_t;

  // storage
  entry_t mem [ENTRIES];
  entry_t rdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  entry_t           wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // control and working registers
  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic                 pend, pend_next;
  logic [IDX_W-1:0]     idx_q, idx_q_next;
  logic [CNT_W-1:0]     wptr, wptr_next;
  logic                 found, found_next;
  logic                 drop, drop_next;
  logic                 full_q, full_q_next;
  logic [IDX_W-1:0]     best_idx, best_idx_next;
  logic [IDX_W-1:0]     best_rank, best_rank_next;
  logic [DATA_BITS-1:0] best_pay, best_pay_next;
  logic [KEY_BITS-1:0]  op_key, op_key_next;
  logic [DATA_BITS-1:0] op_pay, op_pay_next;
  logic                 res_hit, res_hit_next;
  logic [DATA_BITS-1:0] res_pay, res_pay_next;
  logic                 res_evict, res_evict_next;
  logic [CAP_W-1:0]     capacity;

  logic                 in_acc;
  logic                 out_free;
  logic [CNT_W-1:0]     limit;
  logic                 issue;
  logic                 sweep_end;
  logic [EXT_W-1:0]     cap_ext;
  logic [CNT_W-1:0]     eff_cap;
  entry_t               cand;
  logic                 keep;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // capacity above the store size means the store size
  always_comb begin
    cap_ext = EXT_W'(capacity);
    if (cap_ext < EXT_W'(ENTRIES)) begin
      eff_cap = CNT_W'(cap_ext);
    end else begin
      eff_cap = CNT_W'(ENTRIES);
    end
  end

  // a full store sweeps every slot, the least recent one taking the new entry
  assign limit     = (state == ST_PUT && full_q) ? CNT_W'(ENTRIES) : cnt;
  assign issue     = idx < limit;
  assign sweep_end = !issue && !pend;
  assign raddr     = idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    idx_q     <= idx_q_next;
    wptr      <= wptr_next;
    found     <= found_next;
    drop      <= drop_next;
    full_q    <= full_q_next;
    best_idx  <= best_idx_next;
    best_rank <= best_rank_next;
    best_pay  <= best_pay_next;
    op_key    <= op_key_next;
    op_pay    <= op_pay_next;
    res_hit   <= res_hit_next;
    res_pay   <= res_pay_next;
    res_evict <= res_evict_next;
    if (state == ST_DONE && out_free) begin
      hit         <= res_hit;
      payload_out <= res_pay;
      evicted     <= res_evict;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    pend_next      = 1'b0;
    idx_q_next     = idx_q;
    wptr_next      = wptr;
    found_next     = found;
    drop_next      = drop;
    full_q_next    = full_q;
    best_idx_next  = best_idx;
    best_rank_next = best_rank;
    best_pay_next  = best_pay;
    op_key_next    = op_key;
    op_pay_next    = op_pay;
    res_hit_next   = res_hit;
    res_pay_next   = res_pay;
    res_evict_next = res_evict;
    we             = 1'b0;
    waddr          = wptr[IDX_W-1:0];
    wdata          = rdata;
    cand           = rdata;
    keep           = 1'b0;

    if (state == ST_FIND || state == ST_TOUCH || state == ST_PUT) begin
      if (issue) begin
        idx_next   = idx + 1'b1;
        pend_next  = 1'b1;
        idx_q_next = idx[IDX_W-1:0];
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          idx_next    = '0;
          found_next  = 1'b0;
          wptr_next   = '0;
          drop_next   = 1'b0;
          full_q_next = (cnt == CNT_W'(ENTRIES));
          op_key_next = key;
          op_pay_next = payload;
          state_next  = kind ? ST_PUT : ST_FIND;
        end
      end

      ST_FIND: begin
        if (pend && rdata.key == op_key && (!found || rdata.rank < best_rank)) begin
          found_next     = 1'b1;
          best_idx_next  = idx_q;
          best_rank_next = rdata.rank;
          best_pay_next  = rdata.data;
        end
        if (sweep_end) begin
          if (found) begin
            idx_next   = '0;
            state_next = ST_TOUCH;
          end else begin
            res_hit_next   = 1'b0;
            res_pay_next   = '0;
            res_evict_next = 1'b0;
            state_next     = ST_DONE;
          end
        end
      end

      ST_TOUCH: begin
        if (pend) begin
          we    = 1'b1;
          waddr = idx_q;
          wdata = rdata;
          if (idx_q == best_idx) begin
            wdata.rank = '0;
          end else if (rdata.rank < best_rank) begin
            wdata.rank = rdata.rank + 1'b1;
          end
        end
        if (sweep_end) begin
          res_hit_next   = 1'b1;
          res_pay_next   = best_pay;
          res_evict_next = 1'b0;
          state_next     = ST_DONE;
        end
      end

      ST_PUT: begin
        if (pend) begin
          if (full_q && rdata.rank == LAST_RANK) begin
            cand.key  = op_key;
            cand.data = op_pay;
            cand.rank = '0;
          end else begin
            cand.rank = rdata.rank + 1'b1;
          end
          keep = CNT_W'(cand.rank) < eff_cap;
          // survivors slide down in slot order; wptr never passes the read side
          if (keep) begin
            we        = 1'b1;
            wdata     = cand;
            wptr_next = wptr + 1'b1;
          end else begin
            drop_next = 1'b1;
          end
        end
        if (sweep_end) begin
          if (full_q) begin
            cnt_next       = wptr;
            res_hit_next   = 1'b0;
            res_pay_next   = '0;
            res_evict_next = 1'b1;
            state_next     = ST_DONE;
          end else begin
            state_next = ST_PLACE;
          end
        end
      end

      ST_PLACE: begin
        cand.key  = op_key;
        cand.data = op_pay;
        cand.rank = '0;
        keep      = (eff_cap != '0);
        we        = keep;
        wdata     = cand;
        cnt_next       = keep ? wptr + 1'b1 : wptr;
        res_hit_next   = 1'b0;
        res_pay_next   = '0;
        res_evict_next = drop || !keep;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ENTRIES))
    else $error("entry count beyond store size");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("result reports both hit and eviction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (payload_out == '0))
    else $error("payload on a result without hit");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (we && state == ST_PUT) |-> (wptr <= CNT_W'(idx_q)))
    else $error("compaction write ahead of read sweep");

  a_lookup_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !kind) |=> (state == ST_FIND))
    else $error("lookup did not start a key scan");

endmodule
